// ===== rtl/core/ppcalu_pkg.sv =====
// Shared types, operation codes and helpers of the 64-bit fixed-point ALU.
// No dependencies.
`default_nettype none
package ppcalu_pkg;

  localparam logic [5:0] OP_ADD    = 6'd0;
  localparam logic [5:0] OP_ADDC   = 6'd1;
  localparam logic [5:0] OP_ADDE   = 6'd2;
  localparam logic [5:0] OP_ADDIC  = 6'd3;
  localparam logic [5:0] OP_ADDI   = 6'd4;
  localparam logic [5:0] OP_ADDIS  = 6'd5;
  localparam logic [5:0] OP_AND    = 6'd6;
  localparam logic [5:0] OP_ANDC   = 6'd7;
  localparam logic [5:0] OP_ANDI   = 6'd8;
  localparam logic [5:0] OP_ANDIS  = 6'd9;
  localparam logic [5:0] OP_NAND   = 6'd10;
  localparam logic [5:0] OP_NOR    = 6'd11;
  localparam logic [5:0] OP_OR     = 6'd12;
  localparam logic [5:0] OP_ORC    = 6'd13;
  localparam logic [5:0] OP_ORI    = 6'd14;
  localparam logic [5:0] OP_ORIS   = 6'd15;
  localparam logic [5:0] OP_XOR    = 6'd16;
  localparam logic [5:0] OP_XORI   = 6'd17;
  localparam logic [5:0] OP_XORIS  = 6'd18;
  localparam logic [5:0] OP_CMPW   = 6'd19;
  localparam logic [5:0] OP_CMPD   = 6'd20;
  localparam logic [5:0] OP_CMPWI  = 6'd21;
  localparam logic [5:0] OP_CMPDI  = 6'd22;
  localparam logic [5:0] OP_CMPLW  = 6'd23;
  localparam logic [5:0] OP_CMPLD  = 6'd24;
  localparam logic [5:0] OP_CMPLWI = 6'd25;
  localparam logic [5:0] OP_CMPLDI = 6'd26;
  localparam logic [5:0] OP_MULLD  = 6'd27;
  localparam logic [5:0] OP_RLWINM = 6'd28;
  localparam logic [5:0] OP_RLWNM  = 6'd29;
  localparam logic [5:0] OP_RLWIMI = 6'd30;
  localparam logic [5:0] OP_RLDCL  = 6'd31;
  localparam logic [5:0] OP_RLDCR  = 6'd32;
  localparam logic [5:0] OP_RLDIC  = 6'd33;
  localparam logic [5:0] OP_RLDICL = 6'd34;
  localparam logic [5:0] OP_RLDICR = 6'd35;
  localparam logic [5:0] OP_RLDIMI = 6'd36;
  localparam logic [5:0] OP_SLD    = 6'd37;
  localparam logic [5:0] OP_SLW    = 6'd38;
  localparam logic [5:0] OP_SRD    = 6'd39;
  localparam logic [5:0] OP_SRW    = 6'd40;
  localparam logic [5:0] OP_SRADI  = 6'd41;
  localparam logic [5:0] OP_CNTLZD = 6'd42;

  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [5:0]  op;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] s;
    logic [63:0] add_a;
    logic [63:0] add_b;
    logic [63:0] cmp_a;
    logic [63:0] cmp_b;
    logic        cmp_sgn;
    logic [63:0] log_b;
    logic [5:0]  sh;
    logic [5:0]  mb;
    logic [5:0]  me;
    logic        rc;
    logic        is_cmp;
    logic        wr;
    logic [2:0]  crf;
    logic        so;
  } ppcalu_dec_t;

  // ISA MASK(b,e), bit 0 most significant, wraps when b > e
  function automatic logic [63:0] ppc_mask(input logic [5:0] mb, input logic [5:0] me);
    logic [63:0] lo;
    logic [63:0] hi;
    lo = ONES >> mb;
    hi = ONES << (6'd63 - me);
    return (mb <= me) ? (lo & hi) : (lo | hi);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ppcalu_req_if.sv =====
// Request channel of the ALU: one instruction per transaction.
// No dependencies.
`default_nettype none
interface ppcalu_req_if;
  logic        valid;
  logic        ready;
  logic [5:0]  action;
  logic [63:0] value_a;
  logic [63:0] value_b;
  logic [63:0] value_s;
  logic [15:0] immediate;
  logic [5:0]  shift_amount;
  logic [5:0]  mask_begin;
  logic [5:0]  mask_end;
  logic        record;
  logic        a_is_zero_reg;
  logic [2:0]  cr_index;
  logic        summary_overflow_in;

  modport source(output valid, action, value_a, value_b, value_s, immediate, shift_amount,
                 mask_begin, mask_end, record, a_is_zero_reg, cr_index,
                 summary_overflow_in, input ready);
  modport sink(input valid, action, value_a, value_b, value_s, immediate, shift_amount,
               mask_begin, mask_end, record, a_is_zero_reg, cr_index,
               summary_overflow_in, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ppcalu_rsp_if.sv =====
// Response channel of the ALU: one result per transaction.
// No dependencies.
`default_nettype none
interface ppcalu_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic        writes_register;
  logic [3:0]  cr_value;
  logic [2:0]  cr_target;
  logic        cr_valid;
  logic        carry_out;

  modport source(output valid, result, writes_register, cr_value, cr_target, cr_valid,
                 carry_out, input ready);
  modport sink(input valid, result, writes_register, cr_value, cr_target, cr_valid,
               carry_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ppcalu_front.sv =====
// Front end: accepts request transactions and decodes them into operand sets.
// Depends on ppcalu_pkg and ppcalu_req_if.
`default_nettype none
module ppcalu_front
  import ppcalu_pkg::*;
(
  ppcalu_req_if.sink  req,
  output logic        push,
  output ppcalu_dec_t dec,
  input  logic        q_ready
);

  logic [63:0] simm;
  logic [63:0] uimm;
  logic [63:0] a_or_zero;

  assign req.ready = q_ready;
  assign push      = req.valid & q_ready;

  assign simm      = {{48{req.immediate[15]}}, req.immediate};
  assign uimm      = {48'd0, req.immediate};
  assign a_or_zero = req.a_is_zero_reg ? 64'd0 : req.value_a;

  always_comb begin
    dec         = '0;
    dec.op      = req.action;
    dec.a       = req.value_a;
    dec.b       = req.value_b;
    dec.s       = req.value_s;
    dec.sh      = req.shift_amount;
    dec.mb      = req.mask_begin;
    dec.me      = req.mask_end;
    dec.crf     = req.cr_index;
    dec.so      = req.summary_overflow_in;
    dec.rc      = req.record;
    dec.wr      = (req.action <= OP_CNTLZD);
    dec.add_a   = req.value_a;
    dec.add_b   = req.value_b;
    dec.log_b   = req.value_b;
    dec.cmp_a   = req.value_a;
    dec.cmp_b   = req.value_b;
    dec.cmp_sgn = 1'b1;
    unique case (req.action) inside
      OP_ADDIC: dec.add_b = simm;
      OP_ADDI: begin
        dec.add_a = a_or_zero;
        dec.add_b = simm;
        dec.rc    = 1'b0;
      end
      OP_ADDIS: begin
        dec.add_a = a_or_zero;
        dec.add_b = {simm[47:0], 16'd0};
        dec.rc    = 1'b0;
      end
      OP_ANDC, OP_ORC: dec.log_b = ~req.value_b;
      OP_ANDI: begin
        dec.log_b = uimm;
        dec.rc    = 1'b1;
      end
      OP_ANDIS: begin
        dec.log_b = {uimm[47:0], 16'd0};
        dec.rc    = 1'b1;
      end
      OP_ORI, OP_XORI: begin
        dec.log_b = uimm;
        dec.rc    = 1'b0;
      end
      OP_ORIS, OP_XORIS: begin
        dec.log_b = {uimm[47:0], 16'd0};
        dec.rc    = 1'b0;
      end
      OP_CMPW: begin
        dec.cmp_a = {{32{req.value_a[31]}}, req.value_a[31:0]};
        dec.cmp_b = {{32{req.value_b[31]}}, req.value_b[31:0]};
      end
      OP_CMPWI: begin
        dec.cmp_a = {{32{req.value_a[31]}}, req.value_a[31:0]};
        dec.cmp_b = simm;
      end
      OP_CMPDI: dec.cmp_b = simm;
      OP_CMPLW: begin
        dec.cmp_a   = {32'd0, req.value_a[31:0]};
        dec.cmp_b   = {32'd0, req.value_b[31:0]};
        dec.cmp_sgn = 1'b0;
      end
      OP_CMPLD: dec.cmp_sgn = 1'b0;
      OP_CMPLWI: begin
        dec.cmp_a   = {32'd0, req.value_a[31:0]};
        dec.cmp_b   = uimm;
        dec.cmp_sgn = 1'b0;
      end
      OP_CMPLDI: begin
        dec.cmp_b   = uimm;
        dec.cmp_sgn = 1'b0;
      end
      default: ;
    endcase
    if (req.action inside {[OP_CMPW:OP_CMPLDI]}) begin
      dec.is_cmp = 1'b1;
      dec.wr     = 1'b0;
      dec.rc     = 1'b0;
    end
    if (req.action > OP_CNTLZD) begin
      dec.rc = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ppcalu_queue.sv =====
// Two-entry queue between the decode front end and the execute back end.
// Depends on ppcalu_pkg.
`default_nettype none
module ppcalu_queue
  import ppcalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  ppcalu_dec_t push_data,
  output logic        q_ready,
  output logic        head_valid,
  output ppcalu_dec_t head,
  input  logic        pop
);

  ppcalu_dec_t mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign q_ready    = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ppcalu_exec.sv =====
// Back end: executes decoded instructions, keeps XER[CA], registers the response.
// Depends on ppcalu_pkg and ppcalu_rsp_if.
`default_nettype none
module ppcalu_exec
  import ppcalu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  ppcalu_dec_t  head,
  output logic         pop,
  ppcalu_rsp_if.source rsp
);

  logic        carry;
  logic        carry_next;
  logic        mul_phase;
  logic [63:0] p_lo;
  logic [31:0] p_x1;
  logic [31:0] p_x2;
  logic        out_valid;
  logic        can_load;
  logic        is_mul;

  logic [64:0] sum;
  logic [63:0] rsrc;
  logic [5:0]  ramt;
  logic [63:0] rot;
  logic [5:0]  mbs;
  logic [5:0]  mes;
  logic [63:0] mask;
  logic [6:0]  clz;
  logic [63:0] res;
  logic        cmp_lt;
  logic        cmp_gt;
  logic [3:0]  crval;
  logic        crv;
  logic [2:0]  crf;
  logic        is_word_rot;

  assign can_load = ~out_valid | rsp.ready;
  assign is_mul   = (head.op == OP_MULLD);
  assign pop      = head_valid & can_load & (~is_mul | mul_phase);

  assign sum = {1'b0, head.add_a} + {1'b0, head.add_b}
             + {64'd0, (head.op == OP_ADDE) & carry};

  assign is_word_rot = (head.op == OP_RLWINM) || (head.op == OP_RLWNM)
                    || (head.op == OP_RLWIMI);

  always_comb begin
    rsrc = head.s;
    ramt = head.sh;
    mbs  = head.mb;
    mes  = 6'd63;
    if (is_word_rot) begin
      rsrc = {head.s[31:0], head.s[31:0]};
      ramt = (head.op == OP_RLWNM) ? {1'b0, head.b[4:0]} : {1'b0, head.sh[4:0]};
      mbs  = {1'b1, head.mb[4:0]};
      mes  = {1'b1, head.me[4:0]};
    end else if ((head.op == OP_RLDCL) || (head.op == OP_RLDCR)) begin
      ramt = head.b[5:0];
    end
    if ((head.op == OP_RLDCR) || (head.op == OP_RLDICR)) begin
      mbs = 6'd0;
      mes = head.me;
    end else if ((head.op == OP_RLDIC) || (head.op == OP_RLDIMI)) begin
      mes = 6'd63 - head.sh;
    end
  end

  assign rot  = (rsrc << {1'b0, ramt}) | (rsrc >> (7'd64 - {1'b0, ramt}));
  assign mask = ppc_mask(mbs, mes);

  always_comb begin
    clz = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (head.s[i]) clz = 7'(63 - i);
    end
  end

  assign cmp_lt = head.cmp_sgn ? ($signed(head.cmp_a) < $signed(head.cmp_b))
                               : (head.cmp_a < head.cmp_b);
  assign cmp_gt = head.cmp_sgn ? ($signed(head.cmp_a) > $signed(head.cmp_b))
                               : (head.cmp_a > head.cmp_b);

  always_comb begin
    res        = 64'd0;
    carry_next = carry;
    unique case (head.op) inside
      OP_ADD, OP_ADDI, OP_ADDIS: res = sum[63:0];
      OP_ADDC, OP_ADDE, OP_ADDIC: begin
        res        = sum[63:0];
        carry_next = sum[64];
      end
      [OP_AND:OP_ANDIS]:          res = head.s & head.log_b;
      OP_NAND:                    res = ~(head.s & head.b);
      OP_NOR:                     res = ~(head.s | head.b);
      [OP_OR:OP_ORIS]:            res = head.s | head.log_b;
      [OP_XOR:OP_XORIS]:          res = head.s ^ head.log_b;
      OP_MULLD:                   res = p_lo + {p_x1 + p_x2, 32'd0};
      OP_RLWIMI, OP_RLDIMI:       res = (rot & mask) | (head.a & ~mask);
      OP_RLWINM, OP_RLWNM, [OP_RLDCL:OP_RLDICR]: res = rot & mask;
      OP_SLD: res = head.b[6] ? 64'd0 : (head.s << head.b[5:0]);
      OP_SLW: res = head.b[5] ? 64'd0 : {32'd0, head.s[31:0] << head.b[4:0]};
      OP_SRD: res = head.b[6] ? 64'd0 : (head.s >> head.b[5:0]);
      OP_SRW: res = head.b[5] ? 64'd0 : {32'd0, head.s[31:0] >> head.b[4:0]};
      OP_SRADI: begin
        res        = 64'($signed(head.s) >>> head.sh);
        carry_next = head.s[63] & |(head.s & ~(ONES << head.sh));
      end
      OP_CNTLZD: res = {57'd0, clz};
      default: ;
    endcase
  end

  always_comb begin
    crv   = 1'b0;
    crf   = 3'd0;
    crval = 4'd0;
    if (head.is_cmp) begin
      crv   = 1'b1;
      crf   = head.crf;
      crval = {cmp_lt, cmp_gt, ~cmp_lt & ~cmp_gt, head.so};
    end else if (head.wr && head.rc) begin
      crv   = 1'b1;
      crval = {res[63], ~res[63] & (res != 64'd0), res == 64'd0, head.so};
    end
  end

  always_ff @(posedge clk) begin
    if (head_valid && is_mul && !mul_phase) begin
      p_lo <= head.a[31:0] * head.b[31:0];
      p_x1 <= 32'(head.a[31:0] * head.b[63:32]);
      p_x2 <= 32'(head.a[63:32] * head.b[31:0]);
    end
    if (pop) begin
      rsp.result          <= head.wr ? res : 64'd0;
      rsp.writes_register <= head.wr;
      rsp.cr_value        <= crval;
      rsp.cr_target       <= crf;
      rsp.cr_valid        <= crv;
      rsp.carry_out       <= carry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry     <= 1'b0;
      mul_phase <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        carry     <= carry_next;
        mul_phase <= 1'b0;
      end else if (head_valid && is_mul) begin
        mul_phase <= 1'b1;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid = out_valid;

  a_mul_phase_head: assert property (@(posedge clk) disable iff (rst)
    mul_phase |-> (head_valid && is_mul))
    else $error("multiply phase without multiply at head");
  a_no_wr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.writes_register) |-> (rsp.result == 64'd0))
    else $error("non-writing response carries a value");
  a_cr_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.cr_valid) |-> (rsp.cr_value == 4'd0 && rsp.cr_target == 3'd0))
    else $error("CR fields set without cr_valid");
  a_pop_fills: assert property (@(posedge clk) disable iff (rst)
    pop |=> (out_valid && rsp.carry_out == carry))
    else $error("executed instruction lost or carry mismatch");

endmodule
`default_nettype wire

// ===== rtl/core/ppc64_fixed_point_alu_top.sv =====
// 64-bit PowerPC fixed-point ALU: decode front end, two-entry queue, execute back end.
// Path: queue entry, then response register; mulld also registers its partial products first.
// Throughput: one instruction per cycle while the response is accepted; mulld holds the execute
// stage while its 64x64 product is built from registered 32x32 partial products.
// Reset: synchronous rst clears XER[CA], the multiply phase, the queue and the response valid flag.
// Depends on ppcalu_pkg, ppcalu_req_if, ppcalu_rsp_if, ppcalu_front, ppcalu_queue, ppcalu_exec.
`default_nettype none
module ppc64_fixed_point_alu_top
  import ppcalu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  ppcalu_req_if.sink   req,
  ppcalu_rsp_if.source rsp
);

  logic        push;
  logic        q_ready;
  logic        head_valid;
  logic        pop;
  ppcalu_dec_t dec;
  ppcalu_dec_t head;

  ppcalu_front u_front (
    .req     (req),
    .push    (push),
    .dec     (dec),
    .q_ready (q_ready)
  );

  ppcalu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (dec),
    .q_ready    (q_ready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  ppcalu_exec u_exec (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule
`default_nettype wire
